>>> rtl/core/tkh_pkg.sv
// tkh_pkg: shared constants, types and the controller state enum
// for the triple-key hash find-or-insert block; no dependencies
package tkh_pkg;

   localparam int unsigned MAX_BINS_DEF   = 4096;
   localparam int unsigned POOL_DEPTH_DEF = 8192;
   localparam int unsigned NODE_WIDTH_DEF = 20;
   localparam int unsigned ID_WIDTH_DEF   = 8;

   localparam int unsigned LOG2_W   = 4;
   localparam int unsigned TID_W    = 8;
   localparam int unsigned INDEX_W  = 13;
   localparam int unsigned CSR_W    = 8;

   localparam logic CSR_BINS_LOG2 = 1'b0;
   localparam logic CSR_TABLE_ID  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_READ,
      ST_CMP,
      ST_INSERT,
      ST_RESULT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic read_head;
      logic read_entry;
      logic follow;
      logic insert;
      logic set_found;
      logic set_full;
      logic set_new;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_done;
      logic head_nil;
      logic next_nil;
      logic hit;
      logic steps_left;
      logic pool_full;
   } status_type;

endpackage

>>> rtl/core/tkh_ctrl.sv
// tkh_ctrl: controller state machine, clear pass, chain walk, insert
// depends on tkh_pkg
module tkh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  tkh_pkg::status_type sts,
   output tkh_pkg::cmd_type    cmd
);
   import tkh_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_HEAD;
         ST_HEAD:   state_in = ST_READ;
         ST_READ: begin
            if (sts.head_nil) state_in = ST_INSERT;
            else              state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sts.hit) state_in = ST_RESULT;
            else if (sts.next_nil || !sts.steps_left) state_in = ST_INSERT;
            else state_in = ST_CMP;
         end
         ST_INSERT: state_in = ST_RESULT;
         ST_RESULT: if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_HEAD: cmd.read_head = 1'b1;
         ST_READ: cmd.read_entry = !sts.head_nil;
         ST_CMP: begin
            cmd.set_found = sts.hit;
            cmd.follow = !sts.hit && !sts.next_nil && sts.steps_left;
         end
         ST_INSERT: begin
            cmd.insert   = !sts.pool_full;
            cmd.set_new  = !sts.pool_full;
            cmd.set_full = sts.pool_full;
         end
         ST_RESULT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end
endmodule

>>> rtl/core/tkh_dp.sv
// tkh_dp: datapath with bin head memory, key and link pool, result register
// depends on tkh_pkg
module tkh_dp #(
   parameter int unsigned MAX_BINS   = tkh_pkg::MAX_BINS_DEF,
   parameter int unsigned POOL_DEPTH = tkh_pkg::POOL_DEPTH_DEF,
   parameter int unsigned NODE_WIDTH = tkh_pkg::NODE_WIDTH_DEF,
   parameter int unsigned ID_WIDTH   = tkh_pkg::ID_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wen,
   input  logic                         csr_addr,
   input  logic [tkh_pkg::CSR_W-1:0]    csr_wdata,
   input  logic [ID_WIDTH-1:0]          f_id,
   input  logic [NODE_WIDTH-1:0]        f_node,
   input  logic [ID_WIDTH-1:0]          g_id,
   input  logic [NODE_WIDTH-1:0]        g_node,
   input  logic [ID_WIDTH-1:0]          h_id,
   input  logic [NODE_WIDTH-1:0]        h_node,
   input  tkh_pkg::cmd_type             cmd,
   output tkh_pkg::status_type          sts,
   output logic                         found,
   output logic [tkh_pkg::INDEX_W-1:0]  entry_index,
   output logic [tkh_pkg::TID_W-1:0]    result_id,
   output logic                         pool_full
);
   import tkh_pkg::*;

   localparam int unsigned BIN_W = $clog2(MAX_BINS);
   localparam int unsigned PTR_W = $clog2(POOL_DEPTH);
   localparam int unsigned LNK_W = PTR_W + 1;       // holds nil = POOL_DEPTH
   localparam int unsigned KEY_W = ID_WIDTH + NODE_WIDTH;
   localparam int unsigned SUM_W = NODE_WIDTH + 2;
   localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL_DEPTH);

   logic [LOG2_W-1:0] bins_log2_ff;
   logic [TID_W-1:0]  table_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_log2_ff <= LOG2_W'(8);
         table_id_ff  <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_BINS_LOG2: bins_log2_ff <= csr_wdata[LOG2_W-1:0];
            CSR_TABLE_ID:  table_id_ff  <= csr_wdata[TID_W-1:0];
            default: ;
         endcase
      end
   end

   // request keys and bin
   logic [KEY_W-1:0] kf_ff, kg_ff, kh_ff;
   logic [BIN_W-1:0] bin_ff;
   logic [SUM_W-1:0] sum;
   logic [BIN_W-1:0] mask;
   always_comb begin
      sum  = SUM_W'(f_node) + SUM_W'(g_node) + SUM_W'(h_node);
      mask = BIN_W'((32'd1 << bins_log2_ff) - 32'd1);
   end
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kf_ff  <= {f_id, f_node};
         kg_ff  <= {g_id, g_node};
         kh_ff  <= {h_id, h_node};
         bin_ff <= sum[BIN_W-1:0] & mask;
      end
   end

   // pool entries handed out so far
   logic [LNK_W-1:0] used_ff;

   // bin head memory with clearing pass
   logic [LNK_W-1:0] heads_mem [MAX_BINS];
   logic [LNK_W-1:0] head_rd_ff;
   logic [BIN_W:0]   clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_step && !sts.clear_done) clr_ff <= clr_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (cmd.clear_step) heads_mem[clr_ff[BIN_W-1:0]] <= NIL;
      else if (cmd.insert) heads_mem[bin_ff] <= LNK_W'(used_ff);
      if (cmd.read_head) head_rd_ff <= heads_mem[bin_ff];
   end

   // pool: keys plus link in one wide memory
   localparam int unsigned ENT_W = 3 * KEY_W + LNK_W;
   logic [ENT_W-1:0] pool_mem [POOL_DEPTH];
   logic [ENT_W-1:0] ent_rd_ff;
   logic [LNK_W-1:0] cur_ff;
   logic [LNK_W-1:0] steps_ff;
   logic [LNK_W-1:0] rd_addr;

   assign rd_addr = cmd.follow ? ent_rd_ff[LNK_W-1:0] : head_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.insert)
         pool_mem[used_ff[PTR_W-1:0]] <= {kf_ff, kg_ff, kh_ff, head_rd_ff};
      if (cmd.read_entry || cmd.follow) ent_rd_ff <= pool_mem[rd_addr[PTR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (cmd.insert) used_ff <= used_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.read_entry) begin
         cur_ff   <= head_rd_ff;
         steps_ff <= LNK_W'(1);
      end else if (cmd.follow) begin
         cur_ff   <= ent_rd_ff[LNK_W-1:0];
         steps_ff <= steps_ff + 1'b1;
      end
   end

   // result register
   logic                found_ff, full_ff;
   logic [INDEX_W-1:0]  idx_ff;
   always_ff @(posedge clock) begin
      if (cmd.set_found) begin
         found_ff <= 1'b1; full_ff <= 1'b0; idx_ff <= INDEX_W'(cur_ff);
      end else if (cmd.set_new) begin
         found_ff <= 1'b0; full_ff <= 1'b0; idx_ff <= INDEX_W'(used_ff);
      end else if (cmd.set_full) begin
         found_ff <= 1'b0; full_ff <= 1'b1; idx_ff <= '0;
      end
   end

   always_comb begin
      sts.clear_done = (clr_ff == (BIN_W+1)'(MAX_BINS));
      // an entry number at or above the count was never handed out
      sts.head_nil   = (head_rd_ff >= used_ff);
      sts.next_nil   = (ent_rd_ff[LNK_W-1:0] >= used_ff);
      sts.hit        = (ent_rd_ff[ENT_W-1 -: 3*KEY_W] == {kf_ff, kg_ff, kh_ff});
      sts.steps_left = (steps_ff < used_ff);
      sts.pool_full  = (used_ff == NIL);
   end

   assign found       = found_ff;
   assign pool_full   = full_ff;
   assign entry_index = idx_ff;
   assign result_id   = table_id_ff;
endmodule

>>> rtl/core/triple_key_hash_find_or_insert_top.sv
// triple_key_hash_find_or_insert_top: top level of the find-or-insert hash block
// depends on tkh_pkg, tkh_ctrl, tkh_dp
//
//   channel   ports               transfer moves
//   request   req_tvalid/tready   three (id, node) keys
//   result    rsp_tvalid/tready   found, entry index, table id, full flag
//   config    csr_wen/addr/wdata  bins_log2 (0), table_id (1)
//
// a request reads its bin head and the first chain entry, compares chain entries in
// turn, and ends in a hit, an insert or a full-pool reject; the loop is one pool
// memory read per cycle
// after reset a clearing pass sets every bin head to nil, during which no
// request is taken
// one request at a time; the result is held until rsp_tready
module triple_key_hash_find_or_insert_top #(
   parameter int unsigned MAX_BINS   = tkh_pkg::MAX_BINS_DEF,
   parameter int unsigned POOL_DEPTH = tkh_pkg::POOL_DEPTH_DEF,
   parameter int unsigned NODE_WIDTH = tkh_pkg::NODE_WIDTH_DEF,
   parameter int unsigned ID_WIDTH   = tkh_pkg::ID_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // f_id, f_node, g_id, g_node, h_id, h_node, zero fill
   input  logic [((3*(ID_WIDTH+NODE_WIDTH)+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // found, entry_index, result_id, pool_full, zero fill
   output logic [23:0] rsp_tdata,
   input  logic csr_wen,
   input  logic csr_addr,
   input  logic [tkh_pkg::CSR_W-1:0] csr_wdata
);
   import tkh_pkg::*;

   localparam int unsigned KW = ID_WIDTH + NODE_WIDTH;
   localparam int unsigned RW = ((3*KW+7)/8)*8;

   cmd_type    cmd;
   status_type sts;
   logic found, pool_full;
   logic [INDEX_W-1:0] entry_index;
   logic [TID_W-1:0]   result_id;
   logic [RW-1:0]      rq;

   assign rq = req_tdata;

   tkh_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   tkh_dp #(
      .MAX_BINS(MAX_BINS), .POOL_DEPTH(POOL_DEPTH),
      .NODE_WIDTH(NODE_WIDTH), .ID_WIDTH(ID_WIDTH)
   ) u_dp (
      .clock, .reset, .csr_wen, .csr_addr, .csr_wdata,
      .f_id  (rq[ID_WIDTH-1:0]),
      .f_node(rq[KW-1 -: NODE_WIDTH]),
      .g_id  (rq[KW +: ID_WIDTH]),
      .g_node(rq[2*KW-1 -: NODE_WIDTH]),
      .h_id  (rq[2*KW +: ID_WIDTH]),
      .h_node(rq[3*KW-1 -: NODE_WIDTH]),
      .cmd, .sts, .found, .entry_index, .result_id, .pool_full
   );

   // pack the result fields, lowest first
   assign rsp_tdata = {1'b0, pool_full, result_id, entry_index, found};
endmodule

>>> test/triple_key_hash_find_or_insert_top_tb.sv
// triple_key_hash_find_or_insert_top_tb: self-checking bench for the find-or-insert hash block
// drives request, result and config ports, predicts each result in a scoreboard class
// depends on tkh_pkg and triple_key_hash_find_or_insert_top
module triple_key_hash_find_or_insert_top_tb;
   import tkh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BIN_CAP  = 4096;
   localparam int POOL_CAP = 8192;
   localparam int NIL      = POOL_CAP;

   typedef struct {
      bit [7:0]  f_id;
      bit [19:0] f_node;
      bit [7:0]  g_id;
      bit [19:0] g_node;
      bit [7:0]  h_id;
      bit [19:0] h_node;
   } triple_type;

   typedef struct {
      bit        found;
      bit [12:0] entry_index;
      bit [7:0]  result_id;
      bit        pool_full;
   } lookup_type;

   // holds a private copy of the table and the results still owed
   class lookup_scoreboard;
      int        heads[BIN_CAP];
      bit [27:0] key_f[POOL_CAP];
      bit [27:0] key_g[POOL_CAP];
      bit [27:0] key_h[POOL_CAP];
      int        link[POOL_CAP];
      int        used;
      bit [3:0]  bins_log2;
      bit [7:0]  table_id;
      lookup_type owed[$];
      int        errors;

      function void clear();
         foreach (heads[i]) heads[i] = NIL;
         used      = 0;
         bins_log2 = 4'd8;
         table_id  = 8'd0;
         errors    = 0;
      endfunction

      function void note_request(triple_type r);
         bit [27:0] kf, kg, kh;
         bit [21:0] sum;
         int        bin, cur, steps;
         lookup_type res;
         kf  = {r.f_id, r.f_node};
         kg  = {r.g_id, r.g_node};
         kh  = {r.h_id, r.h_node};
         sum = 22'(r.f_node) + 22'(r.g_node) + 22'(r.h_node);
         bin = int'(sum & (((22'd1 << bins_log2) - 22'd1) & 22'(BIN_CAP - 1)));
         cur = heads[bin];
         steps = 0;
         res.result_id = table_id;
         res.found = 1'b0;
         res.pool_full = 1'b0;
         res.entry_index = '0;
         // chain walk, newest entry first
         while (cur < NIL && steps < used) begin
            if (key_f[cur] == kf && key_g[cur] == kg && key_h[cur] == kh) begin
               res.found = 1'b1;
               res.entry_index = cur[12:0];
               break;
            end
            cur = link[cur];
            steps++;
         end
         if (!res.found) begin
            if (used >= POOL_CAP) begin
               res.pool_full = 1'b1;
            end else begin
               key_f[used] = kf;
               key_g[used] = kg;
               key_h[used] = kh;
               link[used]  = heads[bin];
               heads[bin]  = used;
               res.entry_index = used[12:0];
               used++;
            end
         end
         owed.push_back(res);
      endfunction

      function void check_response(logic [23:0] d);
         lookup_type want;
         if (owed.size() == 0) begin
            $error("result transfer with nothing expected: %h", d);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (d[0] !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, d[0]);
            errors++;
         end
         if (d[13:1] !== want.entry_index) begin
            $error("entry_index: expected %0d, actual %0d", want.entry_index, d[13:1]);
            errors++;
         end
         if (d[21:14] !== want.result_id) begin
            $error("result_id: expected %0d, actual %0d", want.result_id, d[21:14]);
            errors++;
         end
         if (d[22] !== want.pool_full) begin
            $error("pool_full: expected %0d, actual %0d", want.pool_full, d[22]);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // f_id, f_node, g_id, g_node, h_id, h_node, zero fill
   logic [87:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // found, entry_index, result_id, pool_full, zero fill
   logic [23:0] rsp_tdata;
   logic        csr_wen;
   logic        csr_addr;
   logic [CSR_W-1:0] csr_wdata;

   lookup_scoreboard sb;
   triple_type       history[$];  // every triple sent so far, source of repeats
   bit               sender_quiet;
   bit               receiver_quiet;
   int               receiver_hold;   // long hold-off, counted down by the receiver

   triple_key_hash_find_or_insert_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop; covers the clearing pass and long chain walks under stalls
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stall bursts, a long hold-off on request, none when quiet
   initial begin
      int burst;
      burst = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_hold > 0) begin
            rsp_tready = 1'b0;
            receiver_hold--;
         end else if (receiver_quiet) begin
            rsp_tready = 1'b1;
         end else if (burst > 0) begin
            rsp_tready = 1'b0;
            burst--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            burst = int'($urandom_range(0, 14));
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // every result transfer is checked at the edge it happens on
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   function automatic logic [87:0] pack_triple(triple_type r);
      return {4'd0, r.h_node, r.h_id, r.g_node, r.g_id, r.f_node, r.f_id};
   endfunction

   // one request transfer; valid stays high into the next call unless a gap comes
   task automatic send_request(triple_type r);
      int gap;
      if (!sender_quiet && $urandom_range(0, 3) == 0) begin
         gap = int'($urandom_range(1, 15));
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pack_triple(r);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      history.push_back(r);
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_tvalid = 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic addr, logic [CSR_W-1:0] value);
      csr_wen   = 1'b1;
      csr_addr  = addr;
      csr_wdata = value;
      if (addr == CSR_BINS_LOG2) sb.bins_log2 = value[3:0];
      else sb.table_id = value;
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   // small node values pile triples into few bins and lengthen chains
   function automatic triple_type fresh_triple();
      triple_type r;
      bit         crowd;
      crowd    = ($urandom_range(0, 3) == 0);
      r.f_id   = 8'($urandom_range(0, 255));
      r.g_id   = 8'($urandom_range(0, 255));
      r.h_id   = 8'($urandom_range(0, 255));
      r.f_node = crowd ? 20'($urandom_range(0, 15)) : 20'($urandom_range(0, 20'hFFFFF));
      r.g_node = crowd ? 20'($urandom_range(0, 15)) : 20'($urandom_range(0, 20'hFFFFF));
      r.h_node = crowd ? 20'($urandom_range(0, 15)) : 20'($urandom_range(0, 20'hFFFFF));
      return r;
   endfunction

   // mix of repeats (hits), near misses and new triples
   function automatic triple_type random_triple();
      triple_type r;
      int         pick;
      pick = int'($urandom_range(0, 9));
      if (history.size() == 0 || pick >= 5) return fresh_triple();
      r = history[$urandom_range(0, history.size() - 1)];
      if (pick == 4) begin
         case ($urandom_range(0, 5))
            0: r.f_id[$urandom_range(0, 7)] ^= 1'b1;
            1: r.g_id[$urandom_range(0, 7)] ^= 1'b1;
            2: r.h_id[$urandom_range(0, 7)] ^= 1'b1;
            3: r.f_node[$urandom_range(0, 19)] ^= 1'b1;
            4: r.g_node[$urandom_range(0, 19)] ^= 1'b1;
            default: r.h_node[$urandom_range(0, 19)] ^= 1'b1;
         endcase
      end
      return r;
   endfunction

   task automatic random_run(int count);
      repeat (count) send_request(random_triple());
   endtask

   initial begin
      triple_type t, zero_t, ones_t;
      sb = new();
      sb.clear();
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_wen        = 1'b0;
      csr_addr       = CSR_BINS_LOG2;
      csr_wdata      = '0;
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      receiver_hold  = 0;
      reset          = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part, 16 bins
      write_csr(CSR_BINS_LOG2, 8'd4);
      write_csr(CSR_TABLE_ID, 8'd0);
      zero_t = '{default: 0};
      ones_t = '{8'hFF, 20'hFFFFF, 8'hFF, 20'hFFFFF, 8'hFF, 20'hFFFFF};
      send_request(zero_t);
      send_request(ones_t);          // node sum carries past 20 bits
      send_request(zero_t);          // hit
      send_request(ones_t);          // hit
      // same bin, keys that differ only in position
      t = zero_t; t.f_node = 20'd1; send_request(t);
      t = zero_t; t.g_node = 20'd1; send_request(t);
      t = zero_t; t.h_node = 20'd1; send_request(t);
      // one id apart from an existing triple: miss into the same chain
      t = zero_t; t.f_id = 8'd1; send_request(t);
      t = zero_t; t.g_id = 8'd1; send_request(t);
      t = zero_t; t.h_id = 8'd1; send_request(t);
      t = zero_t; t.g_node = 20'd1; send_request(t);   // hit deeper in chain
      t = zero_t; t.f_node = 20'd16; send_request(t);  // folds onto bin 0
      send_request(zero_t);          // hit at chain tail
      go_idle();

      // widest setting; receiver holds off long while requests keep coming
      write_csr(CSR_BINS_LOG2, 8'd12);
      write_csr(CSR_TABLE_ID, 8'd255);
      receiver_hold = 300;
      random_run(300);
      go_idle();

      // a single bin: one long chain
      write_csr(CSR_BINS_LOG2, 8'd0);
      write_csr(CSR_TABLE_ID, 8'h5A);
      random_run(120);
      go_idle();

      // above the bin count: clamps to all bins; sender pauses until drained
      write_csr(CSR_BINS_LOG2, 8'd15);
      write_csr(CSR_TABLE_ID, 8'hA5);
      random_run(80);
      req_tvalid = 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      @(negedge clock);
      random_run(80);
      go_idle();

      write_csr(CSR_BINS_LOG2, 8'd7);
      write_csr(CSR_TABLE_ID, 8'd1);
      random_run(300);
      go_idle();

      // last part, no idling: back-to-back requests at the widest setting
      sender_quiet   = 1'b1;
      receiver_quiet = 1'b1;
      write_csr(CSR_BINS_LOG2, 8'd12);
      write_csr(CSR_TABLE_ID, 8'd60);
      random_run(60);
      send_request(ones_t);
      go_idle();

      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/tkh_pkg.sv
rtl/core/tkh_ctrl.sv
rtl/core/tkh_dp.sv
rtl/core/triple_key_hash_find_or_insert_top.sv
test/triple_key_hash_find_or_insert_top_tb.sv
